// ===== rtl/core/p2x_pkg.sv =====
// p2x_pkg: shared types, constants and the pixel rule of the 2x pixel-art upscaler
// no dependencies; imported by every module under rtl/core
`default_nettype none

package p2x_pkg;

  localparam int PIX_W       = 16;
  localparam int ROW_W       = 10;
  localparam int SRC_COL_W   = 10;
  localparam int CFG_W       = 11;
  localparam int MAX_HEIGHT  = 1024;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef logic [PIX_W-1:0]     pix_t;
  typedef logic [ROW_W-1:0]     row_t;
  typedef logic [SRC_COL_W-1:0] src_col_t;

  typedef enum logic [0:0] {
    CMD_PUSH  = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    cmd_e command;
    pix_t pixel;
  } in_item_t;

  typedef struct packed {
    pix_t     top_left;
    pix_t     top_right;
    pix_t     bottom_left;
    pix_t     bottom_right;
    row_t     src_row;
    src_col_t src_col;
    logic     frame_done;
  } out_item_t;

  // classified operation handed from the front end to the back end
  typedef struct packed {
    cmd_e kind;
    logic emit_a;      // push gives the centre one column to the left
    logic emit_b;      // push at the row end also gives its own column
    logic row_ge2;     // row above the centre exists
    logic wr_upper;    // push on a row below the first
    logic first_last;  // first pixel of the frame's last row
    logic last;        // drain of the frame's last pixel
    logic has_next;    // drain centre has a right neighbour
    row_t src_row;
    pix_t pix;
  } ctl_t;

  typedef struct packed {
    pix_t tl;
    pix_t tr;
    pix_t bl;
    pix_t br;
  } quad_t;

  function automatic quad_t scale2x(input pix_t b, input pix_t d, input pix_t e,
                                    input pix_t f, input pix_t h);
    quad_t q;
    q.tl = (d == b && b != f && d != h) ? d : e;
    q.tr = (b == f && b != d && f != h) ? f : e;
    q.bl = (d == h && d != b && h != f) ? d : e;
    q.br = (h == f && d != h && b != f) ? f : e;
    return q;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/p2x_queue.sv =====
// p2x_queue: short operation queue between front end and back end
// depends on p2x_pkg for depth constants
`default_nettype none

module p2x_queue import p2x_pkg::*; #(
  parameter int DW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_i,
  input  wire logic [DW-1:0] wdata_i,
  output logic               full_o,
  input  wire logic          rd_i,
  output logic               valid_o,
  output logic [DW-1:0]      rdata_o
);

  logic [DW-1:0]     mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q + QPTR_W'(wr_i);
    rd_ptr_d = rd_ptr_q + QPTR_W'(rd_i);
    cnt_d    = cnt_q + (QPTR_W + 1)'(wr_i) - (QPTR_W + 1)'(rd_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign full_o  = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== rtl/core/p2x_front.sv =====
// p2x_front: frame size registers, position tracking and classification of input items
// depends on p2x_pkg; feeds p2x_queue
`default_nettype none

module p2x_front import p2x_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [0:0]                   cfg_idx_i,
  input  wire logic [CFG_W-1:0]             cfg_data_i,
  input  wire logic                         in_valid_i,
  input  wire in_item_t                     in_data_i,
  output logic                              in_stall_o,
  input  wire logic                         q_full_i,
  output logic                              op_we_o,
  output ctl_t                              op_ctl_o,
  output logic [$clog2(MAX_WIDTH)-1:0]      op_col_o
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CMP_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;

  function automatic logic [COL_W-1:0] eff_w_m1(input logic [CFG_W-1:0] v);
    logic [CMP_W-1:0] ve;
    logic [COL_W-1:0] r;
    ve = CMP_W'(v);
    if (ve == '0) begin
      r = '0;
    end else if (ve > CMP_W'(MAX_WIDTH)) begin
      r = COL_W'(MAX_WIDTH - 1);
    end else begin
      r = COL_W'(ve - CMP_W'(1));
    end
    return r;
  endfunction

  function automatic row_t eff_h_m1(input logic [CFG_W-1:0] v);
    row_t r;
    if (v == '0) begin
      r = '0;
    end else if (v > CFG_W'(MAX_HEIGHT)) begin
      r = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      r = ROW_W'(v - CFG_W'(1));
    end
    return r;
  endfunction

  logic [COL_W-1:0] w_m1_q;
  row_t             h_m1_q;
  row_t             in_row_q, in_row_d;
  logic [COL_W-1:0] in_col_q, in_col_d;
  logic [COL_W-1:0] drain_col_q, drain_col_d;
  logic             draining_q, draining_d;

  logic             acc;
  logic             is_push;
  logic             col_end;
  ctl_t             ctl;

  assign in_stall_o = q_full_i;
  assign acc        = in_valid_i && !q_full_i;
  assign is_push    = (in_data_i.command == CMD_PUSH);

  always_comb begin
    ctl            = '0;
    ctl.kind       = in_data_i.command;
    ctl.pix        = in_data_i.pixel;
    op_col_o       = is_push ? in_col_q : drain_col_q;
    col_end        = (op_col_o == w_m1_q);
    if (is_push) begin
      ctl.emit_a     = (in_row_q != '0) && (in_col_q != '0);
      ctl.emit_b     = (in_row_q != '0) && col_end;
      ctl.row_ge2    = (in_row_q > ROW_W'(1));
      ctl.wr_upper   = (in_row_q != '0);
      ctl.first_last = (in_row_q == h_m1_q) && (in_col_q == '0);
      ctl.src_row    = in_row_q - ROW_W'(1);
    end else begin
      ctl.row_ge2  = (h_m1_q != '0);
      ctl.last     = col_end;
      ctl.has_next = !col_end;
      ctl.src_row  = h_m1_q;
    end
    op_ctl_o = ctl;
    // pushes while draining and drains outside of draining are dropped
    op_we_o  = acc && (is_push ? !draining_q : draining_q);
  end

  always_comb begin
    in_row_d    = in_row_q;
    in_col_d    = in_col_q;
    drain_col_d = drain_col_q;
    draining_d  = draining_q;
    if (cfg_we_i) begin
      in_row_d    = '0;
      in_col_d    = '0;
      drain_col_d = '0;
      draining_d  = 1'b0;
    end else if (op_we_o) begin
      if (is_push) begin
        if (col_end) begin
          in_col_d = '0;
          if (in_row_q == h_m1_q) begin
            draining_d  = 1'b1;
            drain_col_d = '0;
          end else begin
            in_row_d = in_row_q + ROW_W'(1);
          end
        end else begin
          in_col_d = in_col_q + COL_W'(1);
        end
      end else if (col_end) begin
        in_row_d    = '0;
        in_col_d    = '0;
        drain_col_d = '0;
        draining_d  = 1'b0;
      end else begin
        drain_col_d = drain_col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_m1_q      <= eff_w_m1(CFG_W'(320));
      h_m1_q      <= eff_h_m1(CFG_W'(224));
      in_row_q    <= '0;
      in_col_q    <= '0;
      drain_col_q <= '0;
      draining_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_WIDTH:  w_m1_q <= eff_w_m1(cfg_data_i);
          REG_HEIGHT: h_m1_q <= eff_h_m1(cfg_data_i);
        endcase
      end
      in_row_q    <= in_row_d;
      in_col_q    <= in_col_d;
      drain_col_q <= drain_col_d;
      draining_q  <= draining_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/p2x_back.sv =====
// p2x_back: line buffers, neighbour window and output register of the upscaler
// depends on p2x_pkg; pops operations from p2x_queue
`default_nettype none

module p2x_back import p2x_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    op_valid_i,
  input  wire ctl_t                    op_ctl_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] op_col_i,
  output logic                         op_pop_o,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output out_item_t                    out_data_o
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  pix_t             mid_mem [MAX_WIDTH];
  pix_t             up_mem  [MAX_WIDTH];

  logic             b_vld_q;
  logic             b_part_q;
  ctl_t             b_ctl_q;
  logic [COL_W-1:0] b_col_q;
  pix_t             mid_rd_q, up_rd_q;
  logic             byp_q;
  pix_t             byp_data_q;
  pix_t             prev_mid_q, left_q, prev_up_q, held_q, first_q;
  logic             out_vld_q;
  out_item_t        out_q;

  logic             is_push, dual, sel_a, need, send, done, out_ready;
  logic             pop, mid_we, up_we;
  logic [COL_W-1:0] mid_ra;
  pix_t             up_eff;
  pix_t             nb_b, nb_d, nb_e, nb_f, nb_h;
  quad_t            quad;
  out_item_t        res;

  assign is_push   = (b_ctl_q.kind == CMD_PUSH);
  assign dual      = is_push && b_ctl_q.emit_a && b_ctl_q.emit_b;
  assign sel_a     = is_push && b_ctl_q.emit_a && !b_part_q;
  assign out_ready = !out_vld_q || !out_stall_i;
  assign need      = !is_push || b_part_q || b_ctl_q.emit_a || b_ctl_q.emit_b;
  assign send      = b_vld_q && need && out_ready;
  assign done      = b_vld_q && (!need || (out_ready && !(dual && !b_part_q)));
  assign pop       = op_valid_i && (!b_vld_q || done);
  assign op_pop_o  = pop;

  // drains look one column ahead in the middle line
  assign mid_ra = (op_ctl_i.kind == CMD_DRAIN && op_ctl_i.has_next) ?
                  op_col_i + COL_W'(1) : op_col_i;
  assign mid_we = pop && (op_ctl_i.kind == CMD_PUSH);
  assign up_we  = done && is_push && b_ctl_q.wr_upper;
  assign up_eff = byp_q ? byp_data_q : up_rd_q;

  always_comb begin
    res = '0;
    if (!is_push) begin
      nb_e = (b_col_q == '0) ? first_q : prev_mid_q;
      nb_d = (b_col_q == '0) ? nb_e : left_q;
      nb_f = b_ctl_q.has_next ? mid_rd_q : nb_e;
      nb_b = b_ctl_q.row_ge2 ? up_eff : nb_e;
      nb_h = nb_e;
      res.src_col    = src_col_t'(b_col_q);
      res.frame_done = b_ctl_q.last;
    end else if (sel_a) begin
      nb_e = prev_mid_q;
      nb_d = ((b_col_q >> 1) != '0) ? left_q : nb_e;
      nb_f = mid_rd_q;
      nb_b = b_ctl_q.row_ge2 ? prev_up_q : nb_e;
      nb_h = held_q;
      res.src_col = src_col_t'(b_col_q - COL_W'(1));
    end else begin
      nb_e = mid_rd_q;
      nb_d = (b_col_q != '0) ? prev_mid_q : nb_e;
      nb_f = nb_e;
      nb_b = b_ctl_q.row_ge2 ? up_eff : nb_e;
      nb_h = b_ctl_q.pix;
      res.src_col = src_col_t'(b_col_q);
    end
    quad             = scale2x(nb_b, nb_d, nb_e, nb_f, nb_h);
    res.top_left     = quad.tl;
    res.top_right    = quad.tr;
    res.bottom_left  = quad.bl;
    res.bottom_right = quad.br;
    res.src_row      = b_ctl_q.src_row;
  end

  // middle line: read before write at the same address
  always_ff @(posedge clk_i) begin
    if (pop) begin
      mid_rd_q <= mid_mem[mid_ra];
    end
    if (mid_we) begin
      mid_mem[op_col_i] <= op_ctl_i.pix;
    end
  end

  // upper line takes the old middle value one stage later
  always_ff @(posedge clk_i) begin
    if (pop) begin
      up_rd_q <= up_mem[op_col_i];
    end
    if (up_we) begin
      up_mem[b_col_q] <= mid_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q   <= 1'b0;
      b_part_q  <= 1'b0;
      byp_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (pop) begin
        b_vld_q <= 1'b1;
        byp_q   <= up_we && (op_col_i == b_col_q);
      end else if (done) begin
        b_vld_q <= 1'b0;
      end
      if (done) begin
        b_part_q <= 1'b0;
      end else if (send && dual) begin
        b_part_q <= 1'b1;
      end
      if (out_ready) begin
        out_vld_q <= send;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      b_ctl_q    <= op_ctl_i;
      b_col_q    <= op_col_i;
      byp_data_q <= mid_rd_q;
    end
    if (send) begin
      out_q <= res;
    end
    if (done) begin
      if (is_push) begin
        left_q     <= prev_mid_q;
        prev_mid_q <= mid_rd_q;
        prev_up_q  <= up_eff;
        held_q     <= b_ctl_q.pix;
        if (b_ctl_q.first_last) begin
          first_q <= b_ctl_q.pix;
        end
      end else begin
        left_q     <= nb_e;
        prev_mid_q <= nb_f;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/pixel_art_upscale_2x_top.sv =====
// pixel_art_upscale_2x_top: streaming scale2x upscaler, RGB565 in, 2x2 blocks out
// path: a result passes the operation queue, the back-end operation register and the output register
// throughput: one input transaction per cycle while in_stall_o is low; a row-end push
//   past the first row and column gives two results, absorbed by the 4-entry operation queue
// reset: asynchronous, active low; clears position, drain and handshake state and
//   sets the frame to 320x224; line buffers keep their contents
`default_nettype none

module pixel_art_upscale_2x_top import p2x_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // configuration write port
  input  wire logic             cfg_we_i,
  input  wire logic [0:0]       cfg_idx_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  // source pixel / drain command channel
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire in_item_t         in_data_i,
  // upscaled block channel
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output out_item_t             out_data_o
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int QDW   = $bits(ctl_t) + COL_W;

  // front end to queue
  logic             f_we;
  ctl_t             f_ctl;
  logic [COL_W-1:0] f_col;
  logic             q_full;

  // queue to back end
  logic             q_valid;
  logic             q_pop;
  logic [QDW-1:0]   q_rdata;
  ctl_t             q_ctl;
  logic [COL_W-1:0] q_col;

  // front end: tracks the source position and turns each transaction into an
  // operation, dropping pushes while draining and drains before the last row is complete
  p2x_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .op_we_o    (f_we),
    .op_ctl_o   (f_ctl),
    .op_col_o   (f_col)
  );

  // decouples the input side from output backpressure and the row-end double result
  p2x_queue #(
    .DW(QDW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (f_we),
    .wdata_i ({f_ctl, f_col}),
    .full_o  (q_full),
    .rd_i    (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  assign {q_ctl, q_col} = q_rdata;

  // back end: reads the two line buffers, keeps the sliding neighbour window,
  // applies the scale2x rules and holds the result in the output register
  p2x_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (q_valid),
    .op_ctl_i    (q_ctl),
    .op_col_i    (q_col),
    .op_pop_o    (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// testbench for pixel_art_upscale_2x_top: random and directed frames, scoreboard with a
// cycle-free scale2x predictor; depends on rtl/core/p2x_pkg.sv and the top-level RTL

module testbench;
  import p2x_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_COLS      = 1024;
  localparam int unsigned MAX_ROWS      = MAX_HEIGHT;
  localparam int unsigned SETTLE_CYCLES = 12;   // covers pipeline plus operation queue
  localparam int unsigned LONG_HOLD     = 400;  // receiver hold-off, in cycles
  localparam int unsigned NEVER         = 32'hFFFF_FFFF;
  localparam int unsigned MAX_REPORTS   = 50;

  // scoreboard: mirrors the upscaler state, predicts the 2x2 blocks, checks them in order
  class upscale_scoreboard;
    pix_t             upper_row [MAX_COLS];
    pix_t             middle_row[MAX_COLS];
    int unsigned      next_row;
    int unsigned      next_col;
    int unsigned      drain_pos;
    bit               draining;
    pix_t             prev_pix;        // pixel of the previous push, below the centre
    pix_t             left_of_centre;  // centre row value left of the current centre
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    out_item_t        expected_blocks[$];
    int unsigned      mismatches;

    function new();
      width_reg  = 11'd320;
      height_reg = 11'd224;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      next_row       = 0;
      next_col       = 0;
      drain_pos      = 0;
      draining       = 1'b0;
      prev_pix       = '0;
      left_of_centre = '0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_W-1:0] value);
      if (idx == REG_WIDTH) width_reg = value;
      else height_reg = value;
      restart();
    endfunction

    function int unsigned blocks_due();
      return expected_blocks.size();
    endfunction

    // one scale2x block from the centre and its four neighbours
    function out_item_t make_block(pix_t above, pix_t left, pix_t centre, pix_t right,
                                   pix_t below, int unsigned row, int unsigned col,
                                   bit last);
      out_item_t blk;
      bit        lr_differ;
      bit        ab_differ;
      lr_differ        = (left != right);
      ab_differ        = (above != below);
      blk.top_left     = (left == above && lr_differ && ab_differ) ? left : centre;
      blk.top_right    = (above == right && lr_differ && ab_differ) ? right : centre;
      blk.bottom_left  = (left == below && lr_differ && ab_differ) ? left : centre;
      blk.bottom_right = (below == right && lr_differ && ab_differ) ? right : centre;
      blk.src_row      = row_t'(row);
      blk.src_col      = src_col_t'(col);
      blk.frame_done   = last;
      return blk;
    endfunction

    function void accept_source(in_item_t item);
      int unsigned w;
      int unsigned h;
      int unsigned x;
      int unsigned c;
      int unsigned yr;
      pix_t        centre;
      pix_t        left;
      pix_t        right;
      pix_t        above;
      w = (width_reg == 0) ? 1 : (32'(width_reg) > MAX_COLS) ? MAX_COLS : 32'(width_reg);
      h = (height_reg == 0) ? 1 :
          (32'(height_reg) > MAX_ROWS) ? MAX_ROWS : 32'(height_reg);

      if (item.command == CMD_DRAIN) begin
        if (!draining) return;
        x      = (drain_pos >= w) ? w - 1 : drain_pos;
        centre = middle_row[x];
        left   = (x >= 1) ? middle_row[x-1] : centre;
        right  = (x + 1 < w) ? middle_row[x+1] : centre;
        above  = (h >= 2) ? upper_row[x] : centre;
        expected_blocks.push_back(make_block(above, left, centre, right, centre,
                                             h - 1, x, x == w - 1));
        if (x == w - 1) restart();
        else drain_pos = x + 1;
        return;
      end

      if (draining) return;
      if (next_col >= w) next_col = w - 1;

      if (next_row == 0) begin
        middle_row[next_col] = item.pixel;
      end else begin
        c  = next_col;
        yr = next_row - 1;
        if (c >= 1) begin
          x      = c - 1;
          centre = middle_row[x];
          left   = (x >= 1) ? left_of_centre : centre;
          right  = middle_row[c];
          above  = (yr >= 1) ? upper_row[x] : centre;
          expected_blocks.push_back(make_block(above, left, centre, right, prev_pix,
                                               yr, x, 1'b0));
          upper_row[x]   = centre;
          middle_row[x]  = prev_pix;
          left_of_centre = centre;
        end
        if (c == w - 1) begin
          centre = middle_row[c];
          left   = (c >= 1) ? left_of_centre : centre;
          above  = (yr >= 1) ? upper_row[c] : centre;
          expected_blocks.push_back(make_block(above, left, centre, centre, item.pixel,
                                               yr, c, 1'b0));
          upper_row[c]  = centre;
          middle_row[c] = item.pixel;
        end
      end
      prev_pix = item.pixel;

      next_col++;
      if (next_col >= w) begin
        next_col = 0;
        if (next_row + 1 >= h) begin
          draining  = 1'b1;
          drain_pos = 0;
        end else begin
          next_row++;
        end
      end
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%0t ns mismatch: %s", $realtime, what);
    endtask

    task check_block(out_item_t got);
      out_item_t want;
      if (expected_blocks.size() == 0) begin
        report_mismatch($sformatf("unexpected block row %0d col %0d",
                                  got.src_row, got.src_col));
        return;
      end
      want = expected_blocks.pop_front();
      if (got.top_left !== want.top_left)
        report_mismatch($sformatf("top_left (%0d,%0d) got %h want %h", want.src_row,
                                  want.src_col, got.top_left, want.top_left));
      if (got.top_right !== want.top_right)
        report_mismatch($sformatf("top_right (%0d,%0d) got %h want %h", want.src_row,
                                  want.src_col, got.top_right, want.top_right));
      if (got.bottom_left !== want.bottom_left)
        report_mismatch($sformatf("bottom_left (%0d,%0d) got %h want %h", want.src_row,
                                  want.src_col, got.bottom_left, want.bottom_left));
      if (got.bottom_right !== want.bottom_right)
        report_mismatch($sformatf("bottom_right (%0d,%0d) got %h want %h", want.src_row,
                                  want.src_col, got.bottom_right, want.bottom_right));
      if (got.src_row !== want.src_row)
        report_mismatch($sformatf("src_row got %0d want %0d", got.src_row, want.src_row));
      if (got.src_col !== want.src_col)
        report_mismatch($sformatf("src_col got %0d want %0d", got.src_col, want.src_col));
      if (got.frame_done !== want.frame_done)
        report_mismatch($sformatf("frame_done (%0d,%0d) got %b want %b", want.src_row,
                                  want.src_col, got.frame_done, want.frame_done));
    endtask
  endclass

  // clock, reset and block ports; the driven ones are known from time zero
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [0:0]       cfg_idx_i   = '0;
  logic [CFG_W-1:0] cfg_data_i  = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  in_item_t         in_data_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_item_t        out_data_o;

  upscale_scoreboard board;

  // idle rates of both sides, in percent of cycles
  int unsigned send_idle_pct = 15;
  int unsigned recv_idle_pct = 86;

  // effective frame geometry after the last register writes
  int unsigned frame_cols = 320;
  int unsigned frame_rows = 224;

  // toggled by the stimulus to start one long receiver hold-off
  bit          hold_token = 1'b0;
  bit          hold_seen  = 1'b0;
  int unsigned hold_left  = 0;

  pixel_art_upscale_2x_top #(
    .MAX_WIDTH (MAX_COLS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // receiver: random stall, or a long hold-off when the stimulus asks for one
  always @(negedge clk_i) begin
    if (hold_token != hold_seen) begin
      hold_seen   <= hold_token;
      hold_left   <= LONG_HOLD;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result monitor: a transaction completes when valid is high and stall is low
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_block(out_data_o);
  end

  function automatic in_item_t source_item(cmd_e command, pix_t pixel);
    in_item_t item;
    item.command = command;
    item.pixel   = pixel;
    return item;
  endfunction

  // offer one transaction and hold it until taken; entered and left at a falling edge
  task automatic send_item(input in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.accept_source(item);
    @(negedge clk_i);
  endtask

  // stop offering and wait until every predicted block has come out
  task automatic wait_for_blocks();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (board.blocks_due() != 0) @(negedge clk_i);
  endtask

  // register writes only when idle; a push may still be in flight without any result
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] value);
    int unsigned eff;
    wait_for_blocks();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    board.set_reg(idx, value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    eff = (value == 0) ? 1 : 32'(value);
    if (idx == REG_WIDTH) frame_cols = (eff > MAX_COLS) ? MAX_COLS : eff;
    else frame_rows = (eff > MAX_ROWS) ? MAX_ROWS : eff;
  endtask

  // one frame: w*h pushes then w drains, cut short after cut transactions,
  // with a full pause before transaction pause_at and a little ignored noise
  task automatic run_frame(input int unsigned w, input int unsigned h,
                           input int unsigned cut, input int unsigned pause_at);
    pix_t        colors[3];
    bit          flat;
    int unsigned pushes;
    int unsigned k;
    pushes = w * h;
    // mostly a tiny palette so that neighbours match and the corner rules fire
    flat = ($urandom_range(3) == 0);
    foreach (colors[i]) colors[i] = pix_t'($urandom);
    for (k = 0; k < pushes + w && k < cut; k++) begin
      if (k == pause_at) wait_for_blocks();
      // noise: a drain too early or a push while draining, both ignored
      if ($urandom_range(99) < 3)
        send_item(source_item((k < pushes) ? CMD_DRAIN : CMD_PUSH, pix_t'($urandom)));
      send_item(source_item((k < pushes) ? CMD_PUSH : CMD_DRAIN,
                            flat ? pix_t'($urandom) : colors[$urandom_range(2)]));
    end
  endtask

  // random geometries, mostly small, a few frames per setting, some left unfinished
  task automatic random_stretch(input int unsigned quota);
    int unsigned      sent;
    int unsigned      frames;
    int unsigned      total;
    int unsigned      cut;
    int unsigned      pause_at;
    int unsigned      roll;
    int unsigned      wide;
    bit               only_rows;
    logic [CFG_W-1:0] wv;
    logic [CFG_W-1:0] hv;
    sent = 0;
    while (sent < quota) begin
      roll = $urandom_range(99);
      wv   = CFG_W'((roll < 5)  ? 0 :
                    (roll < 70) ? $urandom_range(8, 1) :
                    (roll < 95) ? $urandom_range(40, 9) : $urandom_range(160, 41));
      only_rows = ($urandom_range(4) == 0);
      wide      = only_rows ? frame_cols : 32'(wv);
      roll      = $urandom_range(99);
      hv   = CFG_W'((wide > 40) ? $urandom_range(3, 1) :
                    (roll < 5)  ? 0 :
                    (roll < 85) ? $urandom_range(6, 1) : $urandom_range(24, 7));
      if (only_rows) begin
        write_reg(REG_HEIGHT, hv);
      end else if ($urandom_range(1) == 0) begin
        write_reg(REG_WIDTH, wv);
        write_reg(REG_HEIGHT, hv);
      end else begin
        write_reg(REG_HEIGHT, hv);
        write_reg(REG_WIDTH, wv);
      end

      frames = $urandom_range(3, 1);
      total  = frame_cols * frame_rows + frame_cols;
      for (int f = 0; f < frames; f++) begin
        // an unfinished frame is always followed by a register write, which restarts it
        cut      = (f == frames - 1 && $urandom_range(6) == 0) ? $urandom_range(total - 1)
                                                               : total;
        pause_at = ($urandom_range(11) == 0) ? $urandom_range(total - 1) : NEVER;
        run_frame(frame_cols, frame_rows, cut, pause_at);
        sent += cut;
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    // corner pattern for a 3x3 frame, raster order, 1 = all ones and 0 = all zeros
    logic [8:0] corner_mask;
    corner_mask = 9'b011110100;
    board = new();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: 3x3 frame of both pixel extremes so every corner rule can fire
    write_reg(REG_WIDTH, 11'd3);
    write_reg(REG_HEIGHT, 11'd3);
    send_item(source_item(CMD_DRAIN, 16'hFFFF));          // drain before the frame ends
    for (int k = 0; k < 9; k++)
      send_item(source_item(CMD_PUSH, corner_mask[k] ? 16'hFFFF : 16'h0000));
    send_item(source_item(CMD_PUSH, 16'h5A5A));           // push while draining
    repeat (3) send_item(source_item(CMD_DRAIN, 16'h0000));
    // zero registers count as 1x1; two frames back to back without a write
    write_reg(REG_WIDTH, 11'd0);
    write_reg(REG_HEIGHT, 11'd0);
    send_item(source_item(CMD_PUSH, 16'hFFFF));
    send_item(source_item(CMD_DRAIN, 16'h0000));
    send_item(source_item(CMD_PUSH, 16'h0000));
    send_item(source_item(CMD_DRAIN, 16'hFFFF));

    // slow receiver
    random_stretch(200);

    // slow sender
    send_idle_pct = 86;
    recv_idle_pct = 15;
    random_stretch(200);

    // full rate; long receiver hold-off fills the block, then a full pause mid-frame
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_WIDTH, 11'd12);
    write_reg(REG_HEIGHT, 11'd6);
    hold_token <= ~hold_token;
    run_frame(12, 6, NEVER, 40);
    random_stretch(200);

    // geometry extremes: one clamped-width row and its first drains, then the start
    // of a clamped-height frame one column wide
    write_reg(REG_WIDTH, 11'h7FF);
    write_reg(REG_HEIGHT, 11'd1);
    run_frame(frame_cols, frame_rows, frame_cols + 8, NEVER);
    write_reg(REG_WIDTH, 11'd1);
    write_reg(REG_HEIGHT, 11'h7FF);
    run_frame(frame_cols, frame_rows, 64, NEVER);

    // drain what is left, then give stray results time to show up
    wait_for_blocks();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (board.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
